/* rtl/epf_pkg.sv */
// ----------------------------------------------------------------------------
// epf_pkg: shared types and constants for the envelope peak finder
// Word layouts, register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package epf_pkg;

    // Default sweep length limit
    localparam int EPF_MAX_SAMPLES = 4096;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int DIST_W   = 16;
    localparam int START_W  = 32;
    localparam int STEP_W   = 24;
    localparam int OFFSET_W = 32;
    localparam int FRAC_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_START_DISTANCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DISTANCE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET           = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMIT   = 3'd4;

    // Register reset values
    localparam logic [START_W-1:0]  START_RESET  = '0;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 24'h01_0000;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;
    localparam logic [SAMPLE_W-1:0] THRESH_RESET = '0;
    localparam logic [DIST_W-1:0]   LIMIT_RESET  = 16'hFFFF;

    // Input word
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last_sample;
    } sample_word_t;

    // Result word
    typedef struct packed {
        logic                is_peak;
        logic [DIST_W-1:0]   distance_mm;
        logic [SAMPLE_W-1:0] amplitude;
        logic [INDEX_W-1:0]  sample_index;
        logic                qualified;
        logic [COUNT_W-1:0]  peak_count;
        logic [COUNT_W-1:0]  qualified_count;
        logic                sweep_end;
    } result_word_t;

endpackage

/* rtl/epf_stream_if.sv */
// ----------------------------------------------------------------------------
// epf_stream_if: valid/ready channels of the envelope peak finder
// One interface for incoming sample words, one for outgoing result words.
// ----------------------------------------------------------------------------
interface epf_sample_if
    import epf_pkg::*;
();
    logic         valid;
    logic         ready;
    sample_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface epf_result_if
    import epf_pkg::*;
();
    logic         valid;
    logic         ready;
    result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/envelope_peak_finder_unit.sv */
// ----------------------------------------------------------------------------
// envelope_peak_finder_unit: streaming local-maximum peak detector
// Finds peaks (with plateau handling) in radar envelope sweeps and reports
// distance, amplitude, index, qualification and running counts.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock and keeps that rate for as long
// as results are taken. A sample decides whether its predecessor is a peak.
// A result word goes from the stage one registers into the output register
// once the output register is free. The first stage holds the
// neighbour compares and the 13x24 index-times-step multiply. The second
// stage holds the Q16.16 add, offset subtract, saturation and qualification.
// Samples that cause no result leave a bubble and nothing is emitted for
// them. The last sample of a sweep always gives a word with sweep_end set
// and clears the sweep state. After MAX_SAMPLES samples, further non-last
// samples are dropped. No clearing pass is needed after reset.
module envelope_peak_finder_unit
    import epf_pkg::*;
#(
    parameter int MAX_SAMPLES = EPF_MAX_SAMPLES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    epf_sample_if.sink            samples,
    epf_result_if.source          results
);

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int PROD_W = CNT_W + STEP_W;
    localparam int POS_W  = ((PROD_W > START_W) ? PROD_W : START_W) + 1;
    localparam int DIFF_W = POS_W + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    // Configuration registers
    logic [START_W-1:0]  start_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [SAMPLE_W-1:0] thresh_reg;
    logic [DIST_W-1:0]   limit_reg;

    // Sweep state
    logic [SAMPLE_W-1:0] older_reg, older_next;
    logic [SAMPLE_W-1:0] middle_reg, middle_next;
    logic [SAMPLE_W-1:0] plateau_reg, plateau_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [COUNT_W-1:0]  raw_total_reg, raw_total_next;
    logic [COUNT_W-1:0]  good_total_reg, good_total_next;

    // First stage
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_peak_reg;
    logic                s1_last_reg;
    logic [SAMPLE_W-1:0] s1_amp_reg;
    logic [INDEX_W-1:0]  s1_idx_reg;
    logic [PROD_W-1:0]   s1_prod_reg;

    // Output register
    logic                out_valid_reg, out_valid_next;
    result_word_t        out_reg;

    // Handshake
    logic in_take;
    logic out_free;
    logic s1_move;

    // Stage one combinational
    logic                active;
    logic                have_two;
    logic                peak;
    logic [CNT_W-1:0]    idx;
    logic [PROD_W-1:0]   prod;

    // Stage two combinational
    logic [POS_W-1:0]    pos;
    logic [DIFF_W-1:0]   diff;
    logic [DIST_W-1:0]   dist_mm;
    logic                qual;
    result_word_t        result_next;

    // ---------------------------------------------------------------- handshake
    assign out_free      = !out_valid_reg || results.ready;
    assign s1_move       = s1_valid_reg && out_free;
    assign samples.ready = !s1_valid_reg || out_free;
    assign in_take       = samples.valid && samples.ready;

    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    // ------------------------------------------------------------ configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= START_RESET;
            step_reg   <= STEP_RESET;
            offset_reg <= OFFSET_RESET;
            thresh_reg <= THRESH_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_DISTANCE:   start_reg  <= cfg_data[START_W-1:0];
                REG_STEP_DISTANCE:    step_reg   <= cfg_data[STEP_W-1:0];
                REG_OFFSET:           offset_reg <= cfg_data[OFFSET_W-1:0];
                REG_AMPLITUDE_THRESH: thresh_reg <= cfg_data[SAMPLE_W-1:0];
                REG_DISTANCE_LIMIT:   limit_reg  <= cfg_data[DIST_W-1:0];
                default:              ;
            endcase
        end
    end

    // ---------------------------------------------- stage one: peak decision
    // Judge the middle sample against its neighbours and the plateau height
    assign active   = cnt_reg < MAX_CNT;
    assign have_two = cnt_reg >= CNT_W'(2);
    assign idx      = cnt_reg - CNT_W'(1);
    assign peak     = active && have_two && (samples.data.sample < middle_reg)
                      && ((middle_reg > older_reg) || (middle_reg == plateau_reg));
    assign prod     = PROD_W'(idx) * PROD_W'(step_reg);

    // Advance the window and plateau tracker; clear after the last sample
    always_comb
    begin
        older_next   = older_reg;
        middle_next  = middle_reg;
        plateau_next = plateau_reg;
        cnt_next     = cnt_reg;
        if (in_take)
        begin
            if (samples.data.last_sample)
            begin
                older_next   = '0;
                middle_next  = '0;
                plateau_next = '0;
                cnt_next     = '0;
            end
            else if (active)
            begin
                if (have_two)
                begin
                    if (middle_reg > plateau_reg && middle_reg > older_reg)
                        plateau_next = middle_reg;
                    else if (middle_reg < older_reg)
                        plateau_next = '0;
                end
                older_next  = middle_reg;
                middle_next = samples.data.sample;
                cnt_next    = cnt_reg + CNT_W'(1);
            end
        end
    end

    // Fill stage one with words that produce a result; drain on move
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = peak || samples.data.last_sample;
        else if (s1_move)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg    <= '0;
            middle_reg   <= '0;
            plateau_reg  <= '0;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            older_reg    <= older_next;
            middle_reg   <= middle_next;
            plateau_reg  <= plateau_next;
            cnt_reg      <= cnt_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Hold the stage one payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_peak_reg <= peak;
            s1_last_reg <= samples.data.last_sample;
            s1_amp_reg  <= peak ? middle_reg : '0;
            s1_idx_reg  <= peak ? INDEX_W'(idx) : '0;
            s1_prod_reg <= prod;
        end
    end

    // ------------------------------------------- stage two: distance and counts
    // Position in Q16.16, minus offset, truncated and saturated to millimetres
    assign pos  = POS_W'(start_reg) + POS_W'(s1_prod_reg);
    assign diff = DIFF_W'(pos) - DIFF_W'(offset_reg);

    always_comb
    begin
        if (diff[DIFF_W-1] || (diff == '0))
            dist_mm = '0;
        else if (|diff[DIFF_W-2:FRAC_W+DIST_W])
            dist_mm = '1;
        else
            dist_mm = diff[FRAC_W+DIST_W-1:FRAC_W];
    end

    assign qual = s1_peak_reg && (s1_amp_reg > thresh_reg) && (dist_mm < limit_reg);

    // Update running counts; clear them once the sweep end word leaves
    always_comb
    begin
        raw_total_next  = raw_total_reg + COUNT_W'(s1_peak_reg);
        good_total_next = good_total_reg + COUNT_W'(qual);

        result_next.is_peak         = s1_peak_reg;
        result_next.distance_mm     = s1_peak_reg ? dist_mm : '0;
        result_next.amplitude       = s1_amp_reg;
        result_next.sample_index    = s1_idx_reg;
        result_next.qualified       = qual;
        result_next.peak_count      = raw_total_next;
        result_next.qualified_count = good_total_next;
        result_next.sweep_end       = s1_last_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_total_reg  <= '0;
            good_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s1_move)
            begin
                raw_total_reg  <= s1_last_reg ? '0 : raw_total_next;
                good_total_reg <= s1_last_reg ? '0 : good_total_next;
            end
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (s1_move)
            out_reg <= result_next;
    end

    // --------------------------------------------------------------- checks
    // A word without a peak is only sent at the end of a sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.data.is_peak |-> results.data.sweep_end)
        else $error("result word carries neither a peak nor a sweep end");

    // Qualification implies a peak
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.qualified |-> results.data.is_peak)
        else $error("qualified flag set on a word without a peak");

    // The sample counter stays within the sweep limit
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CNT)
        else $error("sample counter beyond sweep limit");

    // A last sample restarts the sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take && samples.data.last_sample |=> cnt_reg == '0 && plateau_reg == '0)
        else $error("sweep state not cleared after last sample");

endmodule
